@@ rtl/core/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH     = 16;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int WORD_W    = 32;
    localparam int OUT_CNT_W = 5;

    typedef enum logic [1:0] {
        MODE_PUSH_BACK  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_OVERFLOW  = 2'd2,
        STATUS_RSVD      = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // transaction taken on the request side
        logic load_pop;  // capture RAM read data into the result register
    } deq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_read;  // pending request is a pop on a non-empty queue
        logic full;
        logic empty;
    } deq_stat_t;

endpackage

@@ rtl/core/deq_if.sv @@
// ----------------------------------------------------------------------------
// deq_req_if / deq_rsp_if
// Valid/ready channels for requests and results of the deque unit.
// ----------------------------------------------------------------------------
interface deq_req_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  mode;
    logic signed [31:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface deq_rsp_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic signed [31:0] removed_value;
    logic        [4:0]  count;

    modport source (output valid, output status, output removed_value, output count,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input count,
                    output ready);
endinterface

@@ rtl/core/double_ended_queue_unit.sv @@
// A push or failed pop gives its result from the result registers in the
//   cycle after the transaction; a successful pop goes first through the
//   registered read of the word store RAM, then the result register.
// Pushes go one per cycle while results are taken; a pop's read blocks requests.
// Reset clears the front pointer, count and controller; the store keeps
//   whatever it held and is read only at slots written since.
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Double-ended queue of 32-bit words in a circular store, top level.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
    input  logic       clk,
    input  logic       rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);

    deq_pkg::deq_cmd_t  cmd;
    deq_pkg::deq_stat_t stat;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    deq_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (req.mode),
        .value       (req.value),
        .cmd         (cmd),
        .stat        (stat),
        .rsp_status  (rsp.status),
        .rsp_removed (rsp.removed_value),
        .rsp_count   (rsp.count)
    );

`ifndef ASSERT_OFF
    // an overflow result means the queue is still full while it is shown
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == deq_pkg::STATUS_OVERFLOW) |-> stat.full)
        else $error("overflow reported but queue not full");

    // an underflow result means the queue is still empty and nothing came out
    a_udf_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == deq_pkg::STATUS_UNDERFLOW)
        |-> (stat.empty && rsp.removed_value == '0))
        else $error("underflow reported on non-empty queue");

    // full and empty never both hold
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.full && stat.empty))
        else $error("queue both full and empty");

    // a pop on a non-empty queue goes through the RAM read state before its result shows
    a_pop_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && stat.needs_read) |=> (!rsp.valid && cmd.load_pop))
        else $error("pop result shown without RAM read cycle");
`endif

endmodule

@@ rtl/core/deq_ram.sv @@
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: takes a transaction, waits in the read state for RAM data on a
// pop from a non-empty queue, then holds the result until it is taken.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  deq_pkg::deq_stat_t stat,
    output deq_pkg::deq_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // a new transaction may enter as the held result leaves
    assign req_ready = (state_reg == ST_IDLE) || ((state_reg == ST_OUT) && rsp_ready);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = (state_reg == ST_OUT);

    assign cmd.accept   = accept;
    assign cmd.load_pop = (state_reg == ST_READ);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = stat.needs_read ? ST_READ : ST_OUT;
                end
            end
            ST_READ:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (accept)
                begin
                    state_next = stat.needs_read ? ST_READ : ST_OUT;
                end
                else if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/deq_dpath.sv @@
// ----------------------------------------------------------------------------
// deq_dpath
// Front pointer, count, word store and result registers.
// ----------------------------------------------------------------------------
module deq_dpath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [1:0]                            mode,
    input  logic signed [deq_pkg::WORD_W-1:0]     value,
    input  deq_pkg::deq_cmd_t                     cmd,
    output deq_pkg::deq_stat_t                    stat,
    output logic [1:0]                            rsp_status,
    output logic signed [deq_pkg::WORD_W-1:0]     rsp_removed,
    output logic [deq_pkg::OUT_CNT_W-1:0]         rsp_count
);

    localparam int IDX_W = deq_pkg::IDX_W;
    localparam int CNT_W = deq_pkg::CNT_W;
    localparam int SUM_W = CNT_W + 1;

    logic [IDX_W-1:0]  front_reg;
    logic [IDX_W-1:0]  front_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic [1:0]                       status_reg;
    logic [1:0]                       status_next;
    logic signed [deq_pkg::WORD_W-1:0] removed_reg;
    logic [deq_pkg::OUT_CNT_W-1:0]    rcount_reg;

    logic              is_push;
    logic              full;
    logic              empty;
    logic [SUM_W-1:0]  back_sum;
    logic [SUM_W-1:0]  last_sum;
    logic [IDX_W-1:0]  back_slot;   // one past the back word
    logic [IDX_W-1:0]  last_slot;   // the back word
    logic [IDX_W-1:0]  front_dec;
    logic [IDX_W-1:0]  front_inc;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [deq_pkg::WORD_W-1:0] ram_rdata;

    assign is_push = (mode == deq_pkg::MODE_PUSH_BACK) || (mode == deq_pkg::MODE_PUSH_FRONT);
    assign full    = (count_reg == CNT_W'(deq_pkg::DEPTH));
    assign empty   = (count_reg == '0);

    // front + count stays below 2*DEPTH, so one subtract wraps it
    assign back_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign last_sum  = back_sum - SUM_W'(1);
    assign back_slot = (back_sum >= SUM_W'(deq_pkg::DEPTH)) ?
                       IDX_W'(back_sum - SUM_W'(deq_pkg::DEPTH)) : IDX_W'(back_sum);
    assign last_slot = (last_sum >= SUM_W'(deq_pkg::DEPTH)) ?
                       IDX_W'(last_sum - SUM_W'(deq_pkg::DEPTH)) : IDX_W'(last_sum);
    assign front_dec = (front_reg == '0) ? IDX_W'(deq_pkg::DEPTH - 1) : front_reg - IDX_W'(1);
    assign front_inc = (front_reg == IDX_W'(deq_pkg::DEPTH - 1)) ? '0 : front_reg + IDX_W'(1);

    assign stat.needs_read = !is_push && !empty;
    assign stat.full       = full;
    assign stat.empty      = empty;

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = deq_pkg::STATUS_OK;
        ram_we      = 1'b0;
        ram_waddr   = back_slot;
        ram_raddr   = front_reg;
        case (mode)
            deq_pkg::MODE_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = deq_pkg::STATUS_OVERFLOW;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            deq_pkg::MODE_PUSH_FRONT:
            begin
                ram_waddr = front_dec;
                if (full)
                begin
                    status_next = deq_pkg::STATUS_OVERFLOW;
                end
                else
                begin
                    ram_we     = 1'b1;
                    front_next = front_dec;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            deq_pkg::MODE_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = deq_pkg::STATUS_UNDERFLOW;
                end
                else
                begin
                    front_next = front_inc;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            deq_pkg::MODE_POP_BACK:
            begin
                ram_raddr = last_slot;
                if (empty)
                begin
                    status_next = deq_pkg::STATUS_UNDERFLOW;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = deq_pkg::STATUS_OK;
            end
        endcase
    end

    assign ram_re = cmd.accept;

    deq_ram #(
        .WIDTH (deq_pkg::WORD_W),
        .DEPTH (deq_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we && cmd.accept),
        .waddr (ram_waddr),
        .wdata (value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            status_reg  <= status_next;
            removed_reg <= '0;
            rcount_reg  <= deq_pkg::OUT_CNT_W'(count_next);
        end
        else if (cmd.load_pop)
        begin
            removed_reg <= ram_rdata;
        end
    end

    assign rsp_status  = status_reg;
    assign rsp_removed = removed_reg;
    assign rsp_count   = rcount_reg;

endmodule
